### rtl/core/srbfc_pkg.sv
// Package for the serial ring buffer with RTS/CTS flow control.
// Holds ring sizes, command codes, register indexes and the control/status structs.
// No dependencies.
package srbfc_pkg;

  localparam int RX_DEPTH = 32;
  localparam int TX_DEPTH = 4096;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  localparam int BYTE_W     = 8;
  localparam int WATER_W    = 5;
  localparam int RX_COUNT_W = 6;
  localparam int TX_COUNT_W = 13;
  localparam int RX_CMP_W   = (RX_CW > WATER_W) ? RX_CW : WATER_W;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [WATER_W-1:0] LOW_WATER_RST  = WATER_W'(8);
  localparam logic [WATER_W-1:0] HIGH_WATER_RST = WATER_W'(15);

  // Register index as decoded from paddr[2]
  localparam logic REG_LOW_WATER  = 1'b0;
  localparam logic REG_HIGH_WATER = 1'b1;

  typedef enum logic [2:0] {
    CMD_HOST_WRITE = 3'd0,
    CMD_HOST_READ  = 3'd1,
    CMD_RX_BYTE    = 3'd2,
    CMD_TX_READY   = 3'd3,
    CMD_LINE_CHG   = 3'd4,
    CMD_FLUSH      = 3'd5
  } command_t;

  // Datapath commands issued by the controller for one word
  typedef struct packed {
    logic exec;
    logic tx_wr;
    logic tx_rd;
    logic rx_wr;
    logic rx_rd;
    logic rx_clear;
    logic rts_low_check;
    logic irq_we;
    logic irq_val;
    logic drop;
  } dp_cmd_t;

  // Ring status reported back to the controller
  typedef struct packed {
    logic tx_full;
    logic tx_empty;
    logic rx_full;
    logic rx_empty;
    logic rx_near_full;
  } dp_status_t;

endpackage

### rtl/core/srbfc_ctrl.sv
// Controller for the serial ring buffer: decodes each word into datapath commands
// and sequences the output register. Depends on srbfc_pkg.
module srbfc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             command,
  input  logic                   cts,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  srbfc_pkg::dp_status_t  status,
  output srbfc_pkg::dp_cmd_t     cmd,
  output logic                   load_out
);
  import srbfc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } state_t;

  state_t state;
  logic   exec;

  assign in_stall = (state != ST_IDLE);
  assign exec     = in_valid && (state == ST_IDLE);
  assign load_out = (state == ST_LOAD) && (!out_valid || !out_stall);

  always_comb begin
    cmd      = '0;
    cmd.exec = exec;
    if (exec) begin
      unique case (command)
        CMD_HOST_WRITE: begin
          cmd.tx_wr   = !status.tx_full;
          cmd.irq_we  = !status.tx_full || cts;
          cmd.irq_val = 1'b1;
        end
        CMD_HOST_READ: begin
          cmd.rx_rd         = !status.rx_empty;
          cmd.rts_low_check = 1'b1;
        end
        CMD_RX_BYTE: begin
          cmd.rx_wr = !status.rx_full;
          cmd.drop  = status.rx_full;
        end
        CMD_TX_READY: begin
          cmd.tx_rd   = !status.tx_empty && cts;
          cmd.irq_we  = status.tx_empty || !cts;
          cmd.irq_val = 1'b0;
        end
        CMD_LINE_CHG: begin
          cmd.irq_we  = 1'b1;
          cmd.irq_val = cts;
        end
        CMD_FLUSH: begin
          cmd.rx_clear = status.rx_near_full;
        end
        default: begin
          // unused codes only report status
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (exec) state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/srbfc_datapath.sv
// Datapath for the serial ring buffer: both rings, fill counts, RTS and interrupt
// enable, water mark registers and the output register. Depends on srbfc_pkg.
module srbfc_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  srbfc_pkg::dp_cmd_t                     cmd,
  input  logic [srbfc_pkg::BYTE_W-1:0]           data_byte,
  output srbfc_pkg::dp_status_t                  status,
  input  logic                                   load_out,
  input  logic                                   cfg_we,
  input  logic                                   cfg_idx,
  input  logic [srbfc_pkg::WATER_W-1:0]          cfg_wdata,
  output logic [srbfc_pkg::WATER_W-1:0]          low_water,
  output logic [srbfc_pkg::WATER_W-1:0]          high_water,
  output logic                                   accepted,
  output logic                                   rx_valid,
  output logic [srbfc_pkg::BYTE_W-1:0]           rx_byte,
  output logic                                   tx_valid,
  output logic [srbfc_pkg::BYTE_W-1:0]           tx_byte,
  output logic                                   rts,
  output logic                                   tx_irq_enable,
  output logic                                   dropped,
  output logic [srbfc_pkg::RX_COUNT_W-1:0]       rx_count,
  output logic [srbfc_pkg::TX_COUNT_W-1:0]       tx_count
);
  import srbfc_pkg::*;

  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];

  logic [RX_AW-1:0] rx_head, rx_tail;
  logic [TX_AW-1:0] tx_head, tx_tail;
  logic [RX_CW-1:0] rx_fill, rx_fill_next;
  logic [TX_CW-1:0] tx_fill, tx_fill_next;
  logic             rts_level, tx_irq_on;
  logic [BYTE_W-1:0] rx_rd_data, tx_rd_data;
  logic             accepted_p, rx_valid_p, tx_valid_p, dropped_p;

  assign status.tx_full      = (tx_fill == TX_CW'(TX_DEPTH));
  assign status.tx_empty     = (tx_fill == '0);
  assign status.rx_full      = (rx_fill == RX_CW'(RX_DEPTH));
  assign status.rx_empty     = (rx_fill == '0);
  assign status.rx_near_full = (rx_fill >= RX_CW'(RX_DEPTH - 1));

  always_comb begin
    priority if (cmd.rx_clear) begin
      rx_fill_next = '0;
    end else if (cmd.rx_wr) begin
      rx_fill_next = rx_fill + 1'b1;
    end else if (cmd.rx_rd) begin
      rx_fill_next = rx_fill - 1'b1;
    end else begin
      rx_fill_next = rx_fill;
    end
    priority if (cmd.tx_wr) begin
      tx_fill_next = tx_fill + 1'b1;
    end else if (cmd.tx_rd) begin
      tx_fill_next = tx_fill - 1'b1;
    end else begin
      tx_fill_next = tx_fill;
    end
  end

  // Ring storage: write at head, registered read at tail on each word
  always_ff @(posedge clk) begin
    if (cmd.rx_wr) rx_mem[rx_head] <= data_byte;
    if (cmd.tx_wr) tx_mem[tx_head] <= data_byte;
    if (cmd.exec) begin
      rx_rd_data <= rx_mem[rx_tail];
      tx_rd_data <= tx_mem[tx_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head    <= '0;
      rx_tail    <= '0;
      rx_fill    <= '0;
      tx_head    <= '0;
      tx_tail    <= '0;
      tx_fill    <= '0;
      rts_level  <= 1'b1;
      tx_irq_on  <= 1'b0;
      low_water  <= LOW_WATER_RST;
      high_water <= HIGH_WATER_RST;
      accepted_p <= 1'b0;
      rx_valid_p <= 1'b0;
      tx_valid_p <= 1'b0;
      dropped_p  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_LOW_WATER) low_water <= cfg_wdata;
        if (cfg_idx == REG_HIGH_WATER) high_water <= cfg_wdata;
      end
      if (cmd.exec) begin
        accepted_p <= cmd.tx_wr;
        rx_valid_p <= cmd.rx_rd;
        tx_valid_p <= cmd.tx_rd;
        dropped_p  <= cmd.drop;
      end
      rx_fill <= rx_fill_next;
      tx_fill <= tx_fill_next;
      if (cmd.rx_clear) begin
        rx_head <= '0;
        rx_tail <= '0;
      end else begin
        if (cmd.rx_wr) begin
          rx_head <= (rx_head == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head + 1'b1;
        end
        if (cmd.rx_rd) begin
          rx_tail <= (rx_tail == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail + 1'b1;
        end
      end
      if (cmd.tx_wr) begin
        tx_head <= (tx_head == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head + 1'b1;
      end
      if (cmd.tx_rd) begin
        tx_tail <= (tx_tail == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail + 1'b1;
      end
      priority if (cmd.rx_clear) begin
        rts_level <= 1'b1;
      end else if (cmd.rts_low_check &&
                   (RX_CMP_W'(rx_fill_next) <= RX_CMP_W'(low_water))) begin
        rts_level <= 1'b1;
      end else if (cmd.rx_wr &&
                   (RX_CMP_W'(rx_fill_next) == RX_CMP_W'(high_water))) begin
        rts_level <= 1'b0;
      end
      if (cmd.irq_we) tx_irq_on <= cmd.irq_val;
    end
  end

  // Output register, loaded once the item's ring state has settled
  always_ff @(posedge clk) begin
    if (load_out) begin
      accepted      <= accepted_p;
      rx_valid      <= rx_valid_p;
      rx_byte       <= rx_valid_p ? rx_rd_data : '0;
      tx_valid      <= tx_valid_p;
      tx_byte       <= tx_valid_p ? tx_rd_data : '0;
      rts           <= rts_level;
      tx_irq_enable <= tx_irq_on;
      dropped       <= dropped_p;
      rx_count      <= RX_COUNT_W'(rx_fill);
      tx_count      <= TX_COUNT_W'(tx_fill);
    end
  end

endmodule

### rtl/core/serial_ring_buffer_flow_control.sv
// Top level of the serial ring buffer with RTS/CTS flow control.
// Joins srbfc_ctrl and srbfc_datapath and decodes the APB register port.
// Depends on srbfc_pkg, srbfc_ctrl and srbfc_datapath.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one word per event: command,
//   data_byte and the current cts level. Commands are host write, host read,
//   byte received, transmitter ready, line change and flush on overflow.
//   Output channel (out_valid/out_stall) returns exactly one status word per
//   input word: accepted, rx_valid/rx_byte, tx_valid/tx_byte, rts,
//   tx_irq_enable, dropped, rx_count and tx_count.
//   Sequence: a word accepted in ST_IDLE moves the controller to ST_LOAD,
//   where its result is loaded into the output register once that register
//   is free; the receiver then takes it from there. A new word is taken
//   only in ST_IDLE, after the previous result has been loaded.
//   While the receiver stalls, the finished result holds in the output
//   register and the block may take one more word; that word's result waits
//   in the datapath, and in_stall stays high until it moves to the output.
//   Reset (rst, synchronous) empties both rings, raises RTS, disables the
//   transmit interrupt and loads the water marks with 8 and 15.
//   Registers: low_water at byte 0, high_water at byte 4 (5 bits each).
//   Write them only while the block is idle.
module serial_ring_buffer_flow_control (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           command,
  input  logic [srbfc_pkg::BYTE_W-1:0]         data_byte,
  input  logic                                 cts,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic                                 rx_valid,
  output logic [srbfc_pkg::BYTE_W-1:0]         rx_byte,
  output logic                                 tx_valid,
  output logic [srbfc_pkg::BYTE_W-1:0]         tx_byte,
  output logic                                 rts,
  output logic                                 tx_irq_enable,
  output logic                                 dropped,
  output logic [srbfc_pkg::RX_COUNT_W-1:0]     rx_count,
  output logic [srbfc_pkg::TX_COUNT_W-1:0]     tx_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [srbfc_pkg::CFG_AW-1:0]         paddr,
  input  logic [srbfc_pkg::CFG_DW-1:0]         pwdata,
  output logic [srbfc_pkg::CFG_DW-1:0]         prdata,
  output logic                                 pready
);
  import srbfc_pkg::*;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic              load_out;
  logic              cfg_we;
  logic              cfg_idx;
  logic [WATER_W-1:0] low_water, high_water;

  // APB: zero wait states, register index from address bit 2
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite;
  assign prdata  = CFG_DW'((cfg_idx == REG_HIGH_WATER) ? high_water : low_water);

  srbfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .cts       (cts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .load_out  (load_out)
  );

  srbfc_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .data_byte     (data_byte),
    .status        (status),
    .load_out      (load_out),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (pwdata[WATER_W-1:0]),
    .low_water     (low_water),
    .high_water    (high_water),
    .accepted      (accepted),
    .rx_valid      (rx_valid),
    .rx_byte       (rx_byte),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .rts           (rts),
    .tx_irq_enable (tx_irq_enable),
    .dropped       (dropped),
    .rx_count      (rx_count),
    .tx_count      (tx_count)
  );

endmodule

### rtl/core/srbfc_checker.sv
// Port-level checker for the serial ring buffer, bound to the top level.
// Depends on srbfc_pkg and serial_ring_buffer_flow_control.
module srbfc_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic                                 accepted,
  input logic                                 rx_valid,
  input logic [srbfc_pkg::BYTE_W-1:0]         rx_byte,
  input logic                                 tx_valid,
  input logic [srbfc_pkg::BYTE_W-1:0]         tx_byte,
  input logic                                 dropped,
  input logic [srbfc_pkg::RX_COUNT_W-1:0]     rx_count,
  input logic [srbfc_pkg::TX_COUNT_W-1:0]     tx_count
);
  import srbfc_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rx_count) && $stable(tx_count)
      && $stable(rx_byte) && $stable(tx_byte))
    else $error("stalled result word changed");

  // One word in flight: the block is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word still in work");

  // Each word does at most one ring transfer
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({accepted, rx_valid, tx_valid, dropped}) <= 1)
    else $error("more than one ring action in one result");

  // Bytes read as zero when no transfer took place
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rx_valid || rx_byte == '0) && (tx_valid || tx_byte == '0))
    else $error("byte field set without a transfer");

  // Receive count never exceeds the ring size
  a_rx_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rx_count <= RX_COUNT_W'(RX_DEPTH))
    else $error("receive count above ring size");

endmodule

bind serial_ring_buffer_flow_control srbfc_checker u_srbfc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .accepted  (accepted),
  .rx_valid  (rx_valid),
  .rx_byte   (rx_byte),
  .tx_valid  (tx_valid),
  .tx_byte   (tx_byte),
  .dropped   (dropped),
  .rx_count  (rx_count),
  .tx_count  (tx_count)
);

### test/testbench.sv
// Self-checking testbench for serial_ring_buffer_flow_control: directed table, then random traffic.
// Holds its own model of both rings, RTS and the transmit interrupt enable, checked per word.
// Depends on srbfc_pkg and serial_ring_buffer_flow_control.
module testbench;
  import srbfc_pkg::*;

  // Commands six and seven are undecoded; the block only reports status for them.
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Register byte addresses, built from the index the block decodes on paddr[2].
  localparam logic [CFG_AW-1:0] ADDR_LOW_WATER  = {REG_LOW_WATER, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_HIGH_WATER = {REG_HIGH_WATER, 2'b00};

  localparam int DIRECTED_ROWS = 23;
  localparam int NUM_SEGMENTS  = 12;
  localparam int SEGMENT_WORDS = 135;

  // One status word as the output channel carries it.
  typedef struct packed {
    logic                  accepted;
    logic                  rx_valid;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  tx_valid;
    logic [BYTE_W-1:0]     tx_byte;
    logic                  rts;
    logic                  tx_irq_enable;
    logic                  dropped;
    logic [RX_COUNT_W-1:0] rx_count;
    logic [TX_COUNT_W-1:0] tx_count;
  } status_t;

  // One row of the directed table; typed rows carry a status read straight off the spec.
  typedef struct packed {
    logic [2:0]        cmd;
    logic [BYTE_W-1:0] data;
    logic              cts_level;
    logic              typed;
    status_t           want;
  } row_t;

  // Command mixes for the random segments.
  typedef enum logic [1:0] {
    MIX_RX_FILL    = 2'd0,
    MIX_UNIFORM    = 2'd1,
    MIX_RX_DRAIN   = 2'd2,
    MIX_TX_TRAFFIC = 2'd3
  } traffic_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [2:0]            command;
  logic [BYTE_W-1:0]     data_byte;
  logic                  cts;
  logic                  out_valid;
  logic                  out_stall;
  logic                  accepted;
  logic                  rx_valid;
  logic [BYTE_W-1:0]     rx_byte;
  logic                  tx_valid;
  logic [BYTE_W-1:0]     tx_byte;
  logic                  rts;
  logic                  tx_irq_enable;
  logic                  dropped;
  logic [RX_COUNT_W-1:0] rx_count;
  logic [TX_COUNT_W-1:0] tx_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_AW-1:0]     paddr;
  logic [CFG_DW-1:0]     pwdata;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  serial_ring_buffer_flow_control dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .data_byte     (data_byte),
    .cts           (cts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .accepted      (accepted),
    .rx_valid      (rx_valid),
    .rx_byte       (rx_byte),
    .tx_valid      (tx_valid),
    .tx_byte       (tx_byte),
    .rts           (rts),
    .tx_irq_enable (tx_irq_enable),
    .dropped       (dropped),
    .rx_count      (rx_count),
    .tx_count      (tx_count),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------------------
  // Ring model: our own copy of both rings, the flow-control levels and the
  // water marks. Pointers are sized to the ring so they wrap on their own.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [RX_AW-1:0]  rx_wp, rx_rp;
  logic [TX_AW-1:0]  tx_wp, tx_rp;
  int                rx_fill, tx_fill;
  logic              rts_model, irq_model;
  logic [WATER_W-1:0] low_mark, high_mark;

  status_t pending_status [$];
  int      mismatches;
  logic    steady_sender;
  row_t    directed_rows [DIRECTED_ROWS];

  // Apply one word to the ring model and return the status the block must report.
  function automatic status_t apply_ring_event(input logic [2:0] cmd, input logic [BYTE_W-1:0] data,
                                               input logic cts_in);
    status_t s;
    s = '0;
    case (cmd)
      CMD_HOST_WRITE: begin
        if (tx_fill == TX_DEPTH) begin
          // Refused, but a high CTS still arms the transmit interrupt.
          if (cts_in) irq_model = 1'b1;
        end else begin
          tx_mem[tx_wp] = data;
          tx_wp = tx_wp + 1'b1;
          tx_fill++;
          irq_model = 1'b1;
          s.accepted = 1'b1;
        end
      end
      CMD_HOST_READ: begin
        if (rx_fill != 0) begin
          s.rx_byte = rx_mem[rx_rp];
          s.rx_valid = 1'b1;
          rx_rp = rx_rp + 1'b1;
          rx_fill--;
        end
        // Raise RTS at or below the low mark, an empty ring included.
        if (rx_fill <= int'(low_mark)) rts_model = 1'b1;
      end
      CMD_RX_BYTE: begin
        if (rx_fill == RX_DEPTH) begin
          s.dropped = 1'b1;
        end else begin
          rx_mem[rx_wp] = data;
          rx_wp = rx_wp + 1'b1;
          rx_fill++;
          if (rx_fill == int'(high_mark)) rts_model = 1'b0;
        end
      end
      CMD_TX_READY: begin
        if (tx_fill == 0 || !cts_in) begin
          irq_model = 1'b0;
        end else begin
          s.tx_byte = tx_mem[tx_rp];
          s.tx_valid = 1'b1;
          tx_rp = tx_rp + 1'b1;
          tx_fill--;
        end
      end
      CMD_LINE_CHG: irq_model = cts_in;
      CMD_FLUSH: begin
        // Clear only a ring that is full or one short of full.
        if (rx_fill >= RX_DEPTH - 1) begin
          rx_wp = '0;
          rx_rp = '0;
          rx_fill = 0;
          rts_model = 1'b1;
        end
      end
      default: ;
    endcase
    s.rts = rts_model;
    s.tx_irq_enable = irq_model;
    s.rx_count = RX_COUNT_W'(rx_fill);
    s.tx_count = TX_COUNT_W'(tx_fill);
    return s;
  endfunction

  function automatic status_t status_word(input logic acc, input logic rxv,
                                          input logic [BYTE_W-1:0] rxb, input logic txv,
                                          input logic [BYTE_W-1:0] txb, input logic rts_l,
                                          input logic irq, input logic drp,
                                          input logic [RX_COUNT_W-1:0] rxc,
                                          input logic [TX_COUNT_W-1:0] txc);
    return '{acc, rxv, rxb, txv, txb, rts_l, irq, drp, rxc, txc};
  endfunction

  // Sender pause: mostly back to back, some short gaps, a few long ones.
  function automatic int sender_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_sender || r < 65) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(6, 24));
  endfunction

  function automatic logic [2:0] pick_command(input traffic_t mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_RX_FILL: begin
        if (r < 70) return CMD_RX_BYTE;
        if (r < 82) return CMD_HOST_READ;
        if (r < 92) return CMD_FLUSH;
      end
      MIX_RX_DRAIN: begin
        if (r < 45) return CMD_HOST_READ;
        if (r < 85) return CMD_RX_BYTE;
        if (r < 90) return CMD_FLUSH;
      end
      MIX_TX_TRAFFIC: begin
        if (r < 40) return CMD_HOST_WRITE;
        if (r < 80) return CMD_TX_READY;
        if (r < 90) return CMD_LINE_CHG;
      end
      default: ;
    endcase
    return 3'($urandom_range(0, 7));
  endfunction

  // Offer one word, hold it until it is taken, then log its expected status.
  // Valid stays high into the next word unless a pause is drawn, so it is
  // never lowered and raised in the same step.
  task automatic send_word(input logic [2:0] cmd, input logic [BYTE_W-1:0] data,
                           input logic cts_in, input logic typed, input status_t want);
    status_t predicted;
    int      pause;
    in_valid <= 1'b1;
    command <= cmd;
    data_byte <= data;
    cts <= cts_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_ring_event(cmd, data, cts_in);
    pending_status.push_back(typed ? want : predicted);
    pause = sender_pause();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
  endtask

  task automatic send_random(input logic [2:0] cmd);
    send_word(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  // Drop valid and wait until every status word is back, plus a margin.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup, access, then an idle step so back-to-back writes never
  // put two assignments on a signal in one step.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [WATER_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_LOW_WATER) low_mark = value;
    else high_mark = value;
    @(posedge clk);
  endtask

  task automatic compare_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and run limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard: well past the slowest legal run (every word paying the longest
  // sender gap and the longest receiver stall).
  initial begin
    #12000000;
    $display("serial_ring_buffer_flow_control regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: alternate ready stretches and stalls. Most are short; now and
  // then a long ready stretch lets the block run at full rate.
  // ---------------------------------------------------------------------------
  initial begin : receiver_stall
    int unsigned r;
    out_stall <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 85) repeat ($urandom_range(1, 4)) @(posedge clk);
      else repeat ($urandom_range(20, 120)) @(posedge clk);
      out_stall <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 80) repeat ($urandom_range(1, 3)) @(posedge clk);
      else repeat ($urandom_range(6, 24)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every word taken from the output is matched against the oldest
  // expected status, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_status
    status_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        mismatches++;
        $display("%0t: status word with none expected, rx_count %0d tx_count %0d",
                 $time, rx_count, tx_count);
      end else begin
        want = pending_status.pop_front();
        compare_field("accepted", 16'(want.accepted), 16'(accepted));
        compare_field("rx_valid", 16'(want.rx_valid), 16'(rx_valid));
        compare_field("rx_byte", 16'(want.rx_byte), 16'(rx_byte));
        compare_field("tx_valid", 16'(want.tx_valid), 16'(tx_valid));
        compare_field("tx_byte", 16'(want.tx_byte), 16'(tx_byte));
        compare_field("rts", 16'(want.rts), 16'(rts));
        compare_field("tx_irq_enable", 16'(want.tx_irq_enable), 16'(tx_irq_enable));
        compare_field("dropped", 16'(want.dropped), 16'(dropped));
        compare_field("rx_count", 16'(want.rx_count), 16'(rx_count));
        compare_field("tx_count", 16'(want.tx_count), 16'(tx_count));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int           seg;
    int           row;
    traffic_t     mix;
    logic [WATER_W-1:0] low_sel, high_sel;

    // Hold every input at a known value and reset the block and the model.
    rst <= 1'b1;
    in_valid <= 1'b0;
    command <= CMD_HOST_WRITE;
    data_byte <= '0;
    cts <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_LOW_WATER;
    pwdata <= '0;
    mismatches = 0;
    steady_sender = 1'b0;
    rx_wp = '0;
    rx_rp = '0;
    tx_wp = '0;
    tx_rp = '0;
    rx_fill = 0;
    tx_fill = 0;
    rts_model = 1'b1;
    irq_model = 1'b0;
    low_mark = LOW_WATER_RST;
    high_mark = HIGH_WATER_RST;

    // Directed table, run with the reset water marks (low 8, high 15).
    // Typed rows: status read off the spec; the rest go through the model.
    directed_rows = '{
      // host read and transmitter ready on empty rings
      '{CMD_HOST_READ,  8'h00, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      '{CMD_TX_READY,   8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      // line change follows cts both ways
      '{CMD_LINE_CHG,   8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b1, 1'b0, 6'd0, 13'd0)},
      '{CMD_LINE_CHG,   8'hff, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      // queue byte extremes; each write arms the interrupt
      '{CMD_HOST_WRITE, 8'hff, 1'b0, 1'b1, status_word(1'b1, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b1, 1'b0, 6'd0, 13'd1)},
      '{CMD_HOST_WRITE, 8'h00, 1'b1, 1'b1, status_word(1'b1, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b1, 1'b0, 6'd0, 13'd2)},
      // transmitter ready with cts low only disables the interrupt
      '{CMD_TX_READY,   8'h5a, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd2)},
      '{CMD_TX_READY,   8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b1, 8'hff,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd1)},
      '{CMD_TX_READY,   8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b1, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      '{CMD_TX_READY,   8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      // receive byte extremes
      '{CMD_RX_BYTE,    8'hff, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd1, 13'd0)},
      '{CMD_RX_BYTE,    8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd2, 13'd0)},
      '{CMD_RX_BYTE,    8'ha5, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd3, 13'd0)},
      '{CMD_HOST_READ,  8'h00, 1'b0, 1'b1, status_word(1'b0, 1'b1, 8'hff, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd2, 13'd0)},
      // undecoded commands report status only
      '{CMD_SPARE_6,    8'hff, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd2, 13'd0)},
      '{CMD_SPARE_7,    8'h00, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd2, 13'd0)},
      // flush below the threshold does nothing
      '{CMD_FLUSH,      8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd2, 13'd0)},
      '{CMD_HOST_READ,  8'h00, 1'b0, 1'b1, status_word(1'b0, 1'b1, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd1, 13'd0)},
      '{CMD_HOST_READ,  8'h00, 1'b1, 1'b1, status_word(1'b0, 1'b1, 8'ha5, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      '{CMD_HOST_READ,  8'h00, 1'b0, 1'b1, status_word(1'b0, 1'b0, 8'h00, 1'b0, 8'h00,
                                                       1'b1, 1'b0, 1'b0, 6'd0, 13'd0)},
      // short round trip through the model
      '{CMD_HOST_WRITE, 8'h3c, 1'b1, 1'b0, '0},
      '{CMD_LINE_CHG,   8'hc3, 1'b0, 1'b0, '0},
      '{CMD_TX_READY,   8'h00, 1'b1, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < DIRECTED_ROWS; row++)
      send_word(directed_rows[row].cmd, directed_rows[row].data, directed_rows[row].cts_level,
                directed_rows[row].typed, directed_rows[row].want);

    // Random segments. Each starts idle, loads a new pair of water marks
    // (extremes first, crossed marks included), then runs one command mix.
    for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
      settle();
      case (seg)
        0: begin low_sel = 5'd2;  high_sel = 5'd31; end
        1: begin low_sel = 5'd31; high_sel = 5'd3;  end
        2: begin low_sel = 5'd2;  high_sel = 5'd3;  end
        3: begin low_sel = 5'd31; high_sel = 5'd31; end
        4: begin low_sel = LOW_WATER_RST; high_sel = HIGH_WATER_RST; end
        default: begin
          low_sel = 5'($urandom_range(2, 31));
          high_sel = 5'($urandom_range(3, 31));
        end
      endcase
      write_reg(ADDR_LOW_WATER, low_sel);
      write_reg(ADDR_HIGH_WATER, high_sel);
      mix = traffic_t'(seg % 4);
      steady_sender = (seg % 3 == 2);
      repeat (SEGMENT_WORDS) send_random(pick_command(mix));
    end

    // Close with a short burst of transmit traffic.
    steady_sender = 1'b0;
    repeat (40) send_random(pick_command(MIX_TX_TRAFFIC));

    // Drain the output, leave room for any stray word, then report.
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_ring_buffer_flow_control regression: pass");
    end else begin
      $display("serial_ring_buffer_flow_control regression: fail");
    end
    $finish;
  end

endmodule
